// File: rtl/core/bhe_pkg.sv
// ----------------------------------------------------------------------------
// Bucket histogram engine package
// Shared widths, codes, types and the bound reset table for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bhe_pkg;

  // Field widths.
  localparam int SAMPLE_W = 48;
  localparam int BOUND_W  = 48;
  localparam int CNT_W    = 64;
  localparam int SUM_W    = 64;
  localparam int KIND_W   = 2;
  localparam int BKT_W    = 3;
  localparam int BIU_W    = 3;

  // Number of bound registers and the default number of counters.
  localparam int NUM_BOUNDS      = 6;
  localparam int MAX_BUCKETS_DEF = 6;

  // Depth of the queue between classifier and counter unit.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port: 64-bit data, registers on 8-byte steps.
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  // Register indexes.
  localparam logic [2:0] REG_BOUND_ZERO     = 3'd0;
  localparam logic [2:0] REG_BUCKETS_IN_USE = 3'd6;

  // Item modes.
  localparam logic MODE_OBSERVE = 1'b0;
  localparam logic MODE_READOUT = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BUCKET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INFINITY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUM      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOTAL    = 2'd3;

  // Saturation limits of the sum.
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bound_vec_t;

  // A classified item as it waits in the queue.
  typedef struct packed {
    logic                       readout;
    logic                       hit;
    logic [BKT_W-1:0]           bucket;
    logic signed [SAMPLE_W-1:0] sample;
  } bhe_item_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] fill;
  } bhe_qstat_t;

  // Counter unit sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BUCKET,
    BK_INF,
    BK_SUM,
    BK_TOTAL
  } bk_state_t;

  // Reset value of bound k: k+1 in Q32.16.
  function automatic logic [BOUND_W-1:0] bound_reset(input int k);
    logic [BOUND_W-1:0] v;
    v = BOUND_W'(k + 1);
    return v << 16;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bucket_histogram_engine_top.sv
// ----------------------------------------------------------------------------
// Bucket histogram engine
// Cumulative bucket histogram with programmable ascending bounds: counts
// Q32.16 samples into buckets and reads out cumulative counts, sum and total.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  input     in         push / full           mode, sample_value
//  result    out        pop / empty           result_kind, bucket_number,
//                                             count_value, sum_value,
//                                             last_result
//  config    in         psel/penable/pready   paddr, pwdata, prdata
//
// An observe transfer is classified on entry, queued, and applied to the
// counters by the counter unit one per cycle while no readout is active.
// A readout is fetched from the queue, then holds the counter unit, giving
// one result per cycle through the output register, stalled while pop is low.
// The queue holds four items; full rises when it is filled behind a readout.
// Reset is synchronous: counters, sum and total clear, bounds return to
// 1.0 to 6.0 and six buckets are in use.
// ----------------------------------------------------------------------------
`default_nettype none

module bucket_histogram_engine_top #(
  parameter int MAX_BUCKETS = bhe_pkg::MAX_BUCKETS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input queue side.
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                mode,
  input  wire logic signed [bhe_pkg::SAMPLE_W-1:0] sample_value,
  // Result queue side.
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [bhe_pkg::KIND_W-1:0]               result_kind,
  output logic [bhe_pkg::BKT_W-1:0]                bucket_number,
  output logic [bhe_pkg::CNT_W-1:0]                count_value,
  output logic signed [bhe_pkg::SUM_W-1:0]         sum_value,
  output logic                                     last_result,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bhe_pkg::APB_AW-1:0]          paddr,
  input  wire logic [bhe_pkg::APB_DW-1:0]          pwdata,
  output logic [bhe_pkg::APB_DW-1:0]               prdata,
  output logic                                     pready
);
  import bhe_pkg::*;

  bound_vec_t        bounds;
  logic [BIU_W-1:0]  buckets_in_use;
  logic [BIU_W-1:0]  n_active;
  logic [2:0]        reg_index;
  logic              cfg_wr;

  bhe_item_t         front_item;
  bhe_item_t         q_item;
  bhe_qstat_t        q_status;
  logic              q_pop;
  logic              out_valid;

  // Configuration register file.
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_AW-1:3];
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BOUNDS; k++) begin
        bounds[k] <= bound_reset(k);
      end
      buckets_in_use <= BIU_W'(NUM_BOUNDS);
    end else if (cfg_wr) begin
      for (int k = 0; k < NUM_BOUNDS; k++) begin
        if (reg_index == (REG_BOUND_ZERO + 3'(k))) begin
          bounds[k] <= pwdata[BOUND_W-1:0];
        end
      end
      if (reg_index == REG_BUCKETS_IN_USE) begin
        buckets_in_use <= pwdata[BIU_W-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    for (int k = 0; k < NUM_BOUNDS; k++) begin
      if (reg_index == (REG_BOUND_ZERO + 3'(k))) begin
        prdata = APB_DW'(bounds[k]);
      end
    end
    if (reg_index == REG_BUCKETS_IN_USE) begin
      prdata = APB_DW'(buckets_in_use);
    end
  end

  // Active bucket count, clamped to one and to the counter storage.
  always_comb begin
    if (buckets_in_use == '0) begin
      n_active = BIU_W'(1);
    end else if (buckets_in_use > BIU_W'(MAX_BUCKETS)) begin
      n_active = BIU_W'(MAX_BUCKETS);
    end else begin
      n_active = buckets_in_use;
    end
  end

  // Classifier.
  bhe_front #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_front (
    .mode         (mode),
    .sample_value (sample_value),
    .bounds       (bounds),
    .n_active     (n_active),
    .item         (front_item)
  );

  // Queue between classifier and counter unit.
  bhe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .status  (q_status)
  );

  // Counter unit and readout sequencer.
  bhe_back #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .n_active   (n_active),
    .out_pop    (pop && out_valid),
    .out_valid  (out_valid),
    .out_kind   (result_kind),
    .out_bucket (bucket_number),
    .out_count  (count_value),
    .out_sum    (sum_value),
    .out_last   (last_result)
  );

  assign empty = !out_valid;

  // The queue never reports more entries than it holds.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond its depth");

  // Only the total count result closes a readout.
  a_last_is_total: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_result) |-> (result_kind == KIND_TOTAL))
    else $error("last result is not the total count");

  // A finite bucket result names a bucket in use.
  a_bucket_in_use: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result_kind == KIND_BUCKET)) |-> (bucket_number < n_active))
    else $error("bucket result outside the buckets in use");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire

// File: rtl/core/bhe_front.sv
// ----------------------------------------------------------------------------
// Bucket histogram classifier
// Compares an incoming sample with every active bound in parallel and picks
// the first bucket whose bound is not below the sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bhe_front #(
  parameter int MAX_BUCKETS = bhe_pkg::MAX_BUCKETS_DEF
) (
  input  wire logic                               mode,
  input  wire logic signed [bhe_pkg::SAMPLE_W-1:0] sample_value,
  input  wire bhe_pkg::bound_vec_t                bounds,
  input  wire logic [bhe_pkg::BIU_W-1:0]          n_active,
  output bhe_pkg::bhe_item_t                      item
);
  import bhe_pkg::*;

  logic             hit;
  logic [BKT_W-1:0] bucket;

  // Priority search, lowest index wins.
  always_comb begin
    hit    = 1'b0;
    bucket = '0;
    for (int k = MAX_BUCKETS - 1; k >= 0; k--) begin
      if ((BIU_W'(k) < n_active) && (sample_value <= $signed(bounds[k]))) begin
        hit    = 1'b1;
        bucket = BKT_W'(k);
      end
    end
  end

  // Pack the classified item for the queue.
  always_comb begin
    item.readout = (mode == MODE_READOUT);
    item.hit     = hit;
    item.bucket  = bucket;
    item.sample  = sample_value;
  end

endmodule

`default_nettype wire

// File: rtl/core/bhe_queue.sv
// ----------------------------------------------------------------------------
// Bucket histogram item queue
// Short first-in first-out store that decouples classifier and counter unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bhe_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire bhe_pkg::bhe_item_t wr_item,
  output logic                    full,
  input  wire logic               rd_en,
  output bhe_pkg::bhe_item_t      rd_item,
  output bhe_pkg::bhe_qstat_t     status
);
  import bhe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  bhe_item_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && (fill != '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign rd_item      = entries[rd_ptr];
  assign status.empty = (fill == '0);
  assign status.fill  = fill;

endmodule

`default_nettype wire

// File: rtl/core/bhe_back.sv
// ----------------------------------------------------------------------------
// Bucket histogram counter unit
// Applies observed samples to the counters, sum and total, and walks the
// readout sequence one result per cycle into an output register, stalling while that register holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module bhe_back #(
  parameter int MAX_BUCKETS = bhe_pkg::MAX_BUCKETS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bhe_pkg::bhe_qstat_t           q_status,
  input  wire bhe_pkg::bhe_item_t            q_item,
  output logic                               q_pop,
  input  wire logic [bhe_pkg::BIU_W-1:0]     n_active,
  input  wire logic                          out_pop,
  output logic                               out_valid,
  output logic [bhe_pkg::KIND_W-1:0]         out_kind,
  output logic [bhe_pkg::BKT_W-1:0]          out_bucket,
  output logic [bhe_pkg::CNT_W-1:0]          out_count,
  output logic signed [bhe_pkg::SUM_W-1:0]   out_sum,
  output logic                               out_last
);
  import bhe_pkg::*;

  bk_state_t state, state_next;

  logic [CNT_W-1:0]        counts [MAX_BUCKETS];
  logic [CNT_W-1:0]        total_count;
  logic [SUM_W-1:0]        sample_sum;
  logic [BKT_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        cum, cum_next;

  logic                    adv;
  logic                    observe;
  logic                    emit;
  logic [KIND_W-1:0]       emit_kind;
  logic [BKT_W-1:0]        emit_bucket;
  logic [CNT_W-1:0]        emit_count;
  logic [SUM_W-1:0]        emit_sum;
  logic                    emit_last;
  logic [CNT_W-1:0]        sel_count;
  logic                    last_bucket;

  logic [SUM_W-1:0]        sx;
  logic [SUM_W-1:0]        sum_raw;
  logic                    sum_ovf;
  logic [SUM_W-1:0]        sum_next;

  // The output register can take a new result when empty or being drained.
  assign adv         = !out_valid || out_pop;
  assign last_bucket = ((idx + 1'b1) == n_active);

  // Counter of the bucket currently being read out.
  always_comb begin
    sel_count = '0;
    for (int k = 0; k < MAX_BUCKETS; k++) begin
      if (idx == BKT_W'(k)) begin
        sel_count = counts[k];
      end
    end
  end

  // Saturating add of the sign-extended sample.
  always_comb begin
    sx       = SUM_W'(q_item.sample);
    sum_raw  = sample_sum + sx;
    sum_ovf  = (sample_sum[SUM_W-1] == sx[SUM_W-1]) &&
               (sum_raw[SUM_W-1] != sample_sum[SUM_W-1]);
    sum_next = sum_ovf ? (sx[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_raw;
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty && q_item.readout) begin
          state_next = BK_BUCKET;
        end
      end
      BK_BUCKET: begin
        if (adv && last_bucket) begin
          state_next = BK_INF;
        end
      end
      BK_INF: begin
        if (adv) begin
          state_next = BK_SUM;
        end
      end
      BK_SUM: begin
        if (adv) begin
          state_next = BK_TOTAL;
        end
      end
      BK_TOTAL: begin
        if (adv) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    q_pop       = 1'b0;
    observe     = 1'b0;
    emit        = 1'b0;
    emit_kind   = KIND_BUCKET;
    emit_bucket = '0;
    emit_count  = '0;
    emit_sum    = '0;
    emit_last   = 1'b0;
    idx_next    = idx;
    cum_next    = cum;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop    = 1'b1;
          observe  = !q_item.readout;
          idx_next = '0;
          cum_next = '0;
        end
      end
      BK_BUCKET: begin
        if (adv) begin
          emit        = 1'b1;
          emit_kind   = KIND_BUCKET;
          emit_bucket = idx;
          emit_count  = cum + sel_count;
          cum_next    = cum + sel_count;
          idx_next    = idx + 1'b1;
        end
      end
      BK_INF: begin
        emit       = adv;
        emit_kind  = KIND_INFINITY;
        emit_count = total_count;
      end
      BK_SUM: begin
        emit      = adv;
        emit_kind = KIND_SUM;
        emit_sum  = sample_sum;
      end
      BK_TOTAL: begin
        emit       = adv;
        emit_kind  = KIND_TOTAL;
        emit_count = total_count;
        emit_last  = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
      cum   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cum   <= cum_next;
    end
  end

  // Per-bucket counters, each lane incrementing only itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_BUCKETS; k++) begin
        counts[k] <= '0;
      end
      total_count <= '0;
      sample_sum  <= '0;
    end else if (observe) begin
      for (int k = 0; k < MAX_BUCKETS; k++) begin
        if (q_item.hit && (q_item.bucket == BKT_W'(k))) begin
          counts[k] <= counts[k] + 1'b1;
        end
      end
      total_count <= total_count + 1'b1;
      sample_sum  <= sum_next;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_bucket <= emit_bucket;
      out_count  <= emit_count;
      out_sum    <= emit_sum;
      out_last   <= emit_last;
    end
  end

endmodule

`default_nettype wire
